// ===== rtl/overlay_layer_rank_policy_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Overlay layer rank policy: assertion macros
// Concurrent checks that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef OVERLAY_LAYER_RANK_POLICY_UNIT_MACROS_SVH
`define OVERLAY_LAYER_RANK_POLICY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OLRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("olrp assertion failed");
`define OLRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("olrp assertion failed");
`else
`define OLRP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OLRP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/olrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Overlay layer rank policy: package
// Sizes, codes, types and helpers shared by the block's modules.
// ----------------------------------------------------------------------------
package olrp_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int HISTORY_LIMIT = 10;
    localparam int RING_CAP      = HISTORY_LIMIT + 1;
    localparam int RING_DEPTH    = TABLE_ENTRIES * RING_CAP;

    localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RADDR_W = $clog2(RING_DEPTH);
    localparam int HEAD_W  = (RING_CAP > 1) ? $clog2(RING_CAP) : 1;
    localparam int CNT_W   = $clog2(RING_CAP + 1);
    localparam int SQ_W    = 2 * CNT_W;
    localparam int STAMP_W = 32;
    localparam int SUM_W   = 64;
    localparam int ID_W    = 64;
    localparam int RANK_W  = 5;
    localparam int MAXEN_W = 5;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;
    localparam int G_W     = SUM_W + SQ_W;
    localparam int PROD_W  = 2 * SUM_W + SQ_W;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_MAX_ENABLED = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_STALE_LIMIT = CIDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP1,
        S_POP2,
        S_PUSH,
        S_SCAN,
        S_MULA,
        S_MULB,
        S_FINAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] f;
        logic [SUM_W-1:0] r;
        logic [SQ_W-1:0]  sq;
    } mul_req_t;

    function automatic logic [RADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [HEAD_W-1:0] pos);
        ring_addr = RADDR_W'(slot) * RADDR_W'(RING_CAP) + RADDR_W'(pos);
    endfunction

endpackage

// ===== rtl/olrp_ring_mem.sv =====
// ----------------------------------------------------------------------------
// Overlay layer rank policy: stamp ring memory
// One write port and one registered read port over all surfaces' rings.
// ----------------------------------------------------------------------------
module olrp_ring_mem (
    input  logic                                clk,
    input  logic                                we,
    input  logic [olrp_pkg::RADDR_W-1:0]        waddr,
    input  logic [olrp_pkg::STAMP_W-1:0]        wdata,
    input  logic [olrp_pkg::RADDR_W-1:0]        raddr,
    output logic [olrp_pkg::STAMP_W-1:0]        rdata
);

    logic [olrp_pkg::STAMP_W-1:0] mem [olrp_pkg::RING_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/olrp_mul.sv =====
// ----------------------------------------------------------------------------
// Overlay layer rank policy: score product unit
// Forms F * R * sq exactly: F * sq is formed at start, then one 32x32 multiplier runs six passes.
// ----------------------------------------------------------------------------
module olrp_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  olrp_pkg::mul_req_t                 req,
    output logic                               done,
    output logic [olrp_pkg::PROD_W-1:0]        prod
);

    logic [2:0]                     step_reg;
    logic [olrp_pkg::G_W-1:0]       g_reg;
    logic [olrp_pkg::SUM_W-1:0]     r_reg;
    logic [63:0]                    part_reg;
    logic [1:0]                     sh_reg;
    logic [olrp_pkg::PROD_W-1:0]    acc_reg;
    logic                           done_reg;
    logic [2:0]                     k;
    logic [95:0]                    g_ext;
    logic [31:0]                    ga;
    logic [31:0]                    rb;
    logic [159:0]                   shifted;

    assign k       = step_reg - 3'd1;
    assign g_ext   = 96'(g_reg);
    assign rb      = k[0] ? r_reg[63:32] : r_reg[31:0];
    assign shifted = 160'(part_reg) << {sh_reg, 5'b0};

    always_comb
    begin
        unique case (k[2:1])
            2'd0:    ga = g_ext[31:0];
            2'd1:    ga = g_ext[63:32];
            2'd2:    ga = g_ext[95:64];
            default: ga = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 3'd7);
            if (req.start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg != 3'd0)
            begin
                step_reg <= (step_reg == 3'd7) ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    // Each partial product is registered before it is added to the accumulation.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            g_reg   <= olrp_pkg::G_W'(req.f) * olrp_pkg::G_W'(req.sq);
            r_reg   <= req.r;
            acc_reg <= '0;
        end
        else if (step_reg != 3'd0)
        begin
            if (step_reg >= 3'd2)
            begin
                acc_reg <= acc_reg + shifted[olrp_pkg::PROD_W-1:0];
            end
            if (step_reg <= 3'd6)
            begin
                part_reg <= 64'(ga) * 64'(rb);
                sh_reg   <= k[2:1] + 2'(k[0]);
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/overlay_layer_rank_policy_unit.sv =====
// Flow: tick, delete, insert and unknown or stale query go from decode to the output
// register load; an update goes through the push step, after the pop reads on a full ring.
// A query scans every entry, using the multiplier for each other entry whose score needs it.
// Throughput: one word at a time; a new word is taken once the
// previous one is in the output register.
// Reset: asynchronous, active low; clears the table and vsync counter, loads config defaults.
// ----------------------------------------------------------------------------
// Overlay layer rank policy: top level
// Surface table, update sequencer and rank scan over a shared product unit.
// ----------------------------------------------------------------------------
`include "overlay_layer_rank_policy_unit_macros.svh"

module overlay_layer_rank_policy_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         op,
    input  logic [olrp_pkg::ID_W-1:0]          surface_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               enable,
    output logic [olrp_pkg::RANK_W-1:0]        rank,
    output logic [1:0]                         status,
    input  logic                               cfg_we,
    input  logic [olrp_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [olrp_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [olrp_pkg::SLOT_W-1:0] LAST_SLOT =
        olrp_pkg::SLOT_W'(olrp_pkg::TABLE_ENTRIES - 1);
    localparam logic [olrp_pkg::CNT_W-1:0] FULL_CNT =
        olrp_pkg::CNT_W'(olrp_pkg::RING_CAP);

    olrp_pkg::state_t state_reg, state_next;

    // Control state
    logic [olrp_pkg::STAMP_W-1:0]   vsync_reg, vsync_next;
    logic                           valid_reg [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::MAXEN_W-1:0]   max_en_reg;
    logic [olrp_pkg::STAMP_W-1:0]   stale_reg;
    logic                           out_valid_reg, out_valid_next;

    // Table payload
    logic [olrp_pkg::ID_W-1:0]      id_tab   [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::HEAD_W-1:0]    head_tab [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::CNT_W-1:0]     cnt_tab  [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::STAMP_W-1:0]   tail_tab [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::SUM_W-1:0]     isum_tab [olrp_pkg::TABLE_ENTRIES];
    logic [olrp_pkg::SUM_W-1:0]     rsum_tab [olrp_pkg::TABLE_ENTRIES];

    // Working registers
    logic [1:0]                     op_reg, op_next;
    logic [olrp_pkg::ID_W-1:0]      id_reg, id_next;
    logic [olrp_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [olrp_pkg::SLOT_W-1:0]    j_reg, j_next;
    logic [olrp_pkg::RANK_W-1:0]    cnt_reg, cnt_next;
    logic [olrp_pkg::SUM_W-1:0]     fs_reg, fs_next;
    logic [olrp_pkg::SUM_W-1:0]     rs_reg, rs_next;
    logic [olrp_pkg::PROD_W-1:0]    wa_reg, wa_next;
    logic [olrp_pkg::STAMP_W-1:0]   h_reg, h_next;
    logic [olrp_pkg::STAMP_W-1:0]   nh_reg, nh_next;
    logic                           res_en_reg, res_en_next;
    logic [olrp_pkg::RANK_W-1:0]    res_rank_reg, res_rank_next;
    logic [1:0]                     res_st_reg, res_st_next;
    logic                           o_en_reg, o_en_next;
    logic [olrp_pkg::RANK_W-1:0]    o_rank_reg, o_rank_next;
    logic [1:0]                     o_st_reg, o_st_next;

    // Table write controls
    logic                           tab_we;
    logic                           tab_new;
    logic [olrp_pkg::SLOT_W-1:0]    tab_slot;
    logic [olrp_pkg::HEAD_W-1:0]    tab_head;
    logic [olrp_pkg::CNT_W-1:0]     tab_cnt;
    logic [olrp_pkg::SUM_W-1:0]     tab_isum;
    logic [olrp_pkg::SUM_W-1:0]     tab_rsum;
    logic                           valid_set;
    logic                           valid_clr;

    // Lookup
    logic                           hit;
    logic [olrp_pkg::SLOT_W-1:0]    hit_slot;
    logic                           free_any;
    logic [olrp_pkg::SLOT_W-1:0]    free_slot;

    // Ring memory
    logic                           mem_we;
    logic [olrp_pkg::RADDR_W-1:0]   mem_waddr;
    logic [olrp_pkg::RADDR_W-1:0]   mem_raddr;
    logic [olrp_pkg::STAMP_W-1:0]   mem_rdata;

    // Product unit
    olrp_pkg::mul_req_t             mul_req;
    logic                           mul_done;
    logic [olrp_pkg::PROD_W-1:0]    mul_prod;

    // Push arithmetic
    logic                           do_pop;
    logic [olrp_pkg::HEAD_W-1:0]    head_s;
    logic [olrp_pkg::HEAD_W-1:0]    head_p;
    logic [olrp_pkg::CNT_W-1:0]     cnt_s;
    logic [olrp_pkg::CNT_W-1:0]     cnt_p;
    logic [olrp_pkg::CNT_W:0]       wpos_sum;
    logic [olrp_pkg::HEAD_W-1:0]    wpos;
    logic [olrp_pkg::STAMP_W-1:0]   d_new;
    logic [olrp_pkg::STAMP_W-1:0]   pop_gap;
    logic [olrp_pkg::STAMP_W-1:0]   pop_age;

    // Scan arithmetic
    logic [olrp_pkg::SUM_W-1:0]     ra_j;
    logic                           za_j;
    logic                           zs;
    logic                           j_first;

    function automatic logic [olrp_pkg::SUM_W-1:0] eff_recent(
        input logic [olrp_pkg::SUM_W-1:0]   rsum,
        input logic [olrp_pkg::STAMP_W-1:0] now,
        input logic [olrp_pkg::STAMP_W-1:0] tail,
        input logic [olrp_pkg::CNT_W-1:0]   n);
        logic [olrp_pkg::STAMP_W-1:0] age;
        age = now - tail;
        eff_recent = rsum + olrp_pkg::SUM_W'(age) * olrp_pkg::SUM_W'(n);
    endfunction

    function automatic logic [olrp_pkg::HEAD_W-1:0] head_inc(
        input logic [olrp_pkg::HEAD_W-1:0] hd);
        head_inc = (hd == olrp_pkg::HEAD_W'(olrp_pkg::RING_CAP - 1)) ?
                   '0 : hd + olrp_pkg::HEAD_W'(1);
    endfunction

    olrp_ring_mem u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (vsync_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    olrp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = olrp_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && id_tab[i] == id_reg)
            begin
                hit      = 1'b1;
                hit_slot = olrp_pkg::SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any  = 1'b1;
                free_slot = olrp_pkg::SLOT_W'(i);
            end
        end
    end

    assign head_s   = head_tab[slot_reg];
    assign cnt_s    = cnt_tab[slot_reg];
    assign do_pop   = (cnt_s == FULL_CNT);
    assign head_p   = do_pop ? head_inc(head_s) : head_s;
    assign cnt_p    = do_pop ? cnt_s - olrp_pkg::CNT_W'(1) : cnt_s;
    assign wpos_sum = (olrp_pkg::CNT_W + 1)'(head_p) + (olrp_pkg::CNT_W + 1)'(cnt_p);
    assign wpos     = (wpos_sum >= (olrp_pkg::CNT_W + 1)'(olrp_pkg::RING_CAP)) ?
                      olrp_pkg::HEAD_W'(wpos_sum - (olrp_pkg::CNT_W + 1)'(olrp_pkg::RING_CAP)) :
                      olrp_pkg::HEAD_W'(wpos_sum);
    assign d_new    = vsync_reg - tail_tab[slot_reg];
    assign pop_gap  = nh_reg - h_reg;
    assign pop_age  = vsync_reg - h_reg;

    assign ra_j    = eff_recent(rsum_tab[j_reg], vsync_reg, tail_tab[j_reg], cnt_tab[j_reg]);
    assign za_j    = (isum_tab[j_reg] == '0) || (ra_j == '0);
    assign zs      = (fs_reg == '0) || (rs_reg == '0);
    assign j_first = (j_reg < slot_reg);

    always_comb
    begin
        state_next     = state_reg;
        vsync_next     = vsync_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        slot_next      = slot_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        fs_next        = fs_reg;
        rs_next        = rs_reg;
        wa_next        = wa_reg;
        h_next         = h_reg;
        nh_next        = nh_reg;
        res_en_next    = res_en_reg;
        res_rank_next  = res_rank_reg;
        res_st_next    = res_st_reg;
        o_en_next      = o_en_reg;
        o_rank_next    = o_rank_reg;
        o_st_next      = o_st_reg;
        tab_we         = 1'b0;
        tab_new        = 1'b0;
        tab_slot       = slot_reg;
        tab_head       = head_s;
        tab_cnt        = cnt_s;
        tab_isum       = '0;
        tab_rsum       = '0;
        valid_set      = 1'b0;
        valid_clr      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = olrp_pkg::ring_addr(slot_reg, wpos);
        mem_raddr      = olrp_pkg::ring_addr(slot_reg, head_s);
        mul_req        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            olrp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    id_next    = surface_id;
                    state_next = olrp_pkg::S_DECODE;
                end
            end
            olrp_pkg::S_DECODE:
            begin
                res_en_next   = 1'b0;
                res_rank_next = '0;
                res_st_next   = olrp_pkg::ST_OK;
                state_next    = olrp_pkg::S_EMIT;
                unique case (op_reg)
                    olrp_pkg::OP_TICK:
                    begin
                        vsync_next = vsync_reg + olrp_pkg::STAMP_W'(1);
                    end
                    olrp_pkg::OP_UPDATE:
                    begin
                        if (hit)
                        begin
                            slot_next = hit_slot;
                            mem_raddr = olrp_pkg::ring_addr(hit_slot, head_tab[hit_slot]);
                            state_next = (cnt_tab[hit_slot] == FULL_CNT) ?
                                         olrp_pkg::S_POP1 : olrp_pkg::S_PUSH;
                        end
                        else if (!free_any)
                        begin
                            res_st_next = olrp_pkg::ST_FULL;
                        end
                        else
                        begin
                            tab_we    = 1'b1;
                            tab_new   = 1'b1;
                            tab_slot  = free_slot;
                            tab_head  = '0;
                            tab_cnt   = olrp_pkg::CNT_W'(1);
                            valid_set = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = olrp_pkg::ring_addr(free_slot, '0);
                        end
                    end
                    olrp_pkg::OP_DELETE:
                    begin
                        if (hit)
                        begin
                            tab_slot  = hit_slot;
                            valid_clr = 1'b1;
                        end
                        else
                        begin
                            res_st_next = olrp_pkg::ST_NOT_FOUND;
                        end
                    end
                    olrp_pkg::OP_QUERY:
                    begin
                        if (!hit)
                        begin
                            res_st_next = olrp_pkg::ST_NOT_FOUND;
                        end
                        else if ((vsync_reg - tail_tab[hit_slot]) <= stale_reg)
                        begin
                            slot_next  = hit_slot;
                            fs_next    = isum_tab[hit_slot];
                            rs_next    = eff_recent(rsum_tab[hit_slot], vsync_reg,
                                                    tail_tab[hit_slot], cnt_tab[hit_slot]);
                            cnt_next   = '0;
                            j_next     = '0;
                            state_next = olrp_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_st_next = olrp_pkg::ST_OK;
                    end
                endcase
            end
            olrp_pkg::S_POP1:
            begin
                h_next     = mem_rdata;
                mem_raddr  = olrp_pkg::ring_addr(slot_reg, head_inc(head_s));
                state_next = olrp_pkg::S_POP2;
            end
            olrp_pkg::S_POP2:
            begin
                nh_next    = mem_rdata;
                state_next = olrp_pkg::S_PUSH;
            end
            olrp_pkg::S_PUSH:
            begin
                // A full ring drops its oldest stamp before the new one goes in.
                tab_we   = 1'b1;
                tab_head = head_p;
                tab_cnt  = cnt_p + olrp_pkg::CNT_W'(1);
                tab_isum = isum_tab[slot_reg] + olrp_pkg::SUM_W'(d_new) -
                           (do_pop ? olrp_pkg::SUM_W'(pop_gap) : '0);
                tab_rsum = rsum_tab[slot_reg] +
                           olrp_pkg::SUM_W'(d_new) * olrp_pkg::SUM_W'(cnt_s) -
                           (do_pop ? olrp_pkg::SUM_W'(pop_age) : '0);
                mem_we     = 1'b1;
                state_next = olrp_pkg::S_EMIT;
            end
            olrp_pkg::S_SCAN:
            begin
                if (j_reg != slot_reg && valid_reg[j_reg] && !za_j && !zs)
                begin
                    mul_req.start = 1'b1;
                    mul_req.f     = isum_tab[j_reg];
                    mul_req.r     = ra_j;
                    mul_req.sq    = olrp_pkg::SQ_W'(cnt_s) * olrp_pkg::SQ_W'(cnt_s);
                    state_next    = olrp_pkg::S_MULA;
                end
                else
                begin
                    // A zero score sorts after every nonzero score.
                    if (j_reg != slot_reg && valid_reg[j_reg] &&
                        ((za_j != zs && !za_j) || (za_j && zs && j_first)))
                    begin
                        cnt_next = cnt_reg + olrp_pkg::RANK_W'(1);
                    end
                    if (j_reg == LAST_SLOT)
                    begin
                        state_next = olrp_pkg::S_FINAL;
                    end
                    else
                    begin
                        j_next = j_reg + olrp_pkg::SLOT_W'(1);
                    end
                end
            end
            olrp_pkg::S_MULA:
            begin
                if (mul_done)
                begin
                    wa_next       = mul_prod;
                    mul_req.start = 1'b1;
                    mul_req.f     = fs_reg;
                    mul_req.r     = rs_reg;
                    mul_req.sq    = olrp_pkg::SQ_W'(cnt_tab[j_reg]) *
                                    olrp_pkg::SQ_W'(cnt_tab[j_reg]);
                    state_next    = olrp_pkg::S_MULB;
                end
            end
            olrp_pkg::S_MULB:
            begin
                if (mul_done)
                begin
                    if (wa_reg < mul_prod || (wa_reg == mul_prod && j_first))
                    begin
                        cnt_next = cnt_reg + olrp_pkg::RANK_W'(1);
                    end
                    if (j_reg == LAST_SLOT)
                    begin
                        state_next = olrp_pkg::S_FINAL;
                    end
                    else
                    begin
                        j_next     = j_reg + olrp_pkg::SLOT_W'(1);
                        state_next = olrp_pkg::S_SCAN;
                    end
                end
            end
            olrp_pkg::S_FINAL:
            begin
                res_en_next   = (olrp_pkg::MAXEN_W'(cnt_reg) < max_en_reg);
                res_rank_next = cnt_reg;
                state_next    = olrp_pkg::S_EMIT;
            end
            olrp_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_en_next      = res_en_reg;
                    o_rank_next    = res_rank_reg;
                    o_st_next      = res_st_reg;
                    state_next     = olrp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olrp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olrp_pkg::S_IDLE;
            vsync_reg     <= '0;
            out_valid_reg <= 1'b0;
            max_en_reg    <= olrp_pkg::MAXEN_W'(8);
            stale_reg     <= olrp_pkg::STAMP_W'(100);
            for (int i = 0; i < olrp_pkg::TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            vsync_reg     <= vsync_next;
            out_valid_reg <= out_valid_next;
            if (valid_set)
            begin
                valid_reg[tab_slot] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[tab_slot] <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    olrp_pkg::CFG_MAX_ENABLED: max_en_reg <= cfg_data[olrp_pkg::MAXEN_W-1:0];
                    olrp_pkg::CFG_STALE_LIMIT: stale_reg  <= cfg_data;
                    default:                   stale_reg  <= stale_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        slot_reg     <= slot_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        fs_reg       <= fs_next;
        rs_reg       <= rs_next;
        wa_reg       <= wa_next;
        h_reg        <= h_next;
        nh_reg       <= nh_next;
        res_en_reg   <= res_en_next;
        res_rank_reg <= res_rank_next;
        res_st_reg   <= res_st_next;
        o_en_reg     <= o_en_next;
        o_rank_reg   <= o_rank_next;
        o_st_reg     <= o_st_next;
        if (tab_we)
        begin
            head_tab[tab_slot] <= tab_head;
            cnt_tab[tab_slot]  <= tab_cnt;
            tail_tab[tab_slot] <= vsync_reg;
            isum_tab[tab_slot] <= tab_isum;
            rsum_tab[tab_slot] <= tab_rsum;
        end
        if (tab_new)
        begin
            id_tab[tab_slot] <= id_reg;
        end
    end

    assign in_stall  = (state_reg != olrp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign enable    = o_en_reg;
    assign rank      = o_rank_reg;
    assign status    = o_st_reg;

    `OLRP_ASSERT_IMP(a_mul_done_in_wait, clk, rst_n, mul_done, (state_reg == olrp_pkg::S_MULA || state_reg == olrp_pkg::S_MULB))
    `OLRP_ASSERT_IMP(a_enable_ok, clk, rst_n, out_valid && enable, status == olrp_pkg::ST_OK && rank < olrp_pkg::RANK_W'(olrp_pkg::TABLE_ENTRIES))
    `OLRP_ASSERT_NXT(a_emit_loads, clk, rst_n, state_reg == olrp_pkg::S_EMIT && !(out_valid && out_stall), out_valid && state_reg == olrp_pkg::S_IDLE)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlay layer rank policy: testbench
// Drives ticks, updates, deletes and queries with random gaps and output
// stalls, predicts every answer from a local copy of the surface table and
// checks each result word field by field, over several register settings.
// ----------------------------------------------------------------------------

class rank_scoreboard;
    bit [4:0]  max_en;
    bit [31:0] stale_lim;
    bit [31:0] vcount;
    bit        used[olrp_pkg::TABLE_ENTRIES];
    bit [63:0] ids[olrp_pkg::TABLE_ENTRIES];
    bit [31:0] stamps[olrp_pkg::TABLE_ENTRIES][olrp_pkg::RING_CAP];
    int        head[olrp_pkg::TABLE_ENTRIES];
    int        cnt[olrp_pkg::TABLE_ENTRIES];
    bit [63:0] isum[olrp_pkg::TABLE_ENTRIES];
    bit [63:0] rsum[olrp_pkg::TABLE_ENTRIES];
    bit [7:0]  answers[$];
    int        errors;

    function void clear();
        max_en = 8;
        stale_lim = 100;
        vcount = 0;
        errors = 0;
        foreach (used[i]) used[i] = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] val);
        if (idx == olrp_pkg::CFG_MAX_ENABLED)
            max_en = val[4:0];
        else if (idx == olrp_pkg::CFG_STALE_LIMIT)
            stale_lim = val;
    endfunction

    function int find(bit [63:0] id);
        for (int i = 0; i < olrp_pkg::TABLE_ENTRIES; i++)
            if (used[i] && ids[i] == id)
                return i;
        return -1;
    endfunction

    function bit [31:0] newest(int s);
        return stamps[s][(head[s] + cnt[s] - 1) % olrp_pkg::RING_CAP];
    endfunction

    function bit [63:0] recency(int s);
        bit [63:0] age;
        age = {32'd0, vcount - newest(s)};
        return rsum[s] + age * 64'(cnt[s]);
    endfunction

    // Scores are compared as F_a*R_a*n_b^2 against F_b*R_b*n_a^2.
    function bit ranks_ahead(int a, int b);
        bit [63:0]  ra, rb;
        bit [135:0] pa, pb;
        bit         za, zb;
        ra = recency(a);
        rb = recency(b);
        za = (isum[a] == 0 || ra == 0);
        zb = (isum[b] == 0 || rb == 0);
        if (za != zb)
            return !za;
        if (za)
            return a < b;
        pa = 136'(isum[a]) * 136'(ra) * 136'(cnt[b] * cnt[b]);
        pb = 136'(isum[b]) * 136'(rb) * 136'(cnt[a] * cnt[a]);
        if (pa != pb)
            return pa < pb;
        return a < b;
    endfunction

    function bit [1:0] update(bit [63:0] id);
        int        s, n;
        bit [31:0] oldest, last, d;
        s = find(id);
        if (s < 0) begin
            for (s = 0; s < olrp_pkg::TABLE_ENTRIES; s++)
                if (!used[s])
                    break;
            if (s == olrp_pkg::TABLE_ENTRIES)
                return olrp_pkg::ST_FULL;
            used[s] = 1;
            ids[s] = id;
            head[s] = 0;
            cnt[s] = 1;
            stamps[s][0] = vcount;
            isum[s] = 0;
            rsum[s] = 0;
            return olrp_pkg::ST_OK;
        end
        n = cnt[s];
        oldest = stamps[s][head[s]];
        last = newest(s);
        if (n > olrp_pkg::HISTORY_LIMIT) begin
            head[s] = (head[s] + 1) % olrp_pkg::RING_CAP;
            cnt[s]--;
            isum[s] -= {32'd0, stamps[s][head[s]] - oldest};
            rsum[s] -= {32'd0, vcount - oldest};
        end
        d = vcount - last;
        isum[s] += {32'd0, d};
        rsum[s] += {32'd0, d} * 64'(n);
        stamps[s][(head[s] + cnt[s]) % olrp_pkg::RING_CAP] = vcount;
        cnt[s]++;
        return olrp_pkg::ST_OK;
    endfunction

    function void note_word(bit [1:0] op, bit [63:0] id);
        bit       en;
        bit [4:0] rk;
        bit [1:0] st;
        int       s, c;
        en = 0;
        rk = 0;
        st = olrp_pkg::ST_OK;
        case (op)
            olrp_pkg::OP_TICK: vcount++;
            olrp_pkg::OP_UPDATE: st = update(id);
            olrp_pkg::OP_DELETE: begin
                s = find(id);
                if (s < 0) st = olrp_pkg::ST_NOT_FOUND;
                else used[s] = 0;
            end
            default: begin
                s = find(id);
                if (s < 0)
                    st = olrp_pkg::ST_NOT_FOUND;
                else if (vcount - newest(s) <= stale_lim) begin
                    c = 0;
                    for (int j = 0; j < olrp_pkg::TABLE_ENTRIES; j++)
                        if (j != s && used[j] && ranks_ahead(j, s))
                            c++;
                    en = (c < max_en);
                    rk = c[4:0];
                end
            end
        endcase
        answers.insert(answers.size(), {en, rk, st});
    endfunction

    function void check_word(bit en, bit [4:0] rk, bit [1:0] st);
        bit [7:0] want;
        if (answers.size() == 0) begin
            $display("%0t: result with nothing expected: enable %0d rank %0d status %0d",
                     $time, en, rk, st);
            errors++;
            return;
        end
        want = answers.pop_front();
        if (want[7] != en) begin
            $display("%0t: enable expected %0d, got %0d", $time, want[7], en);
            errors++;
        end
        if (want[6:2] != rk) begin
            $display("%0t: rank expected %0d, got %0d", $time, want[6:2], rk);
            errors++;
        end
        if (want[1:0] != st) begin
            $display("%0t: status expected %0d, got %0d", $time, want[1:0], st);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [63:0] surface_id;
    logic        out_valid;
    logic        out_stall;
    logic        enable;
    logic [4:0]  rank;
    logic [1:0]  status;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    rank_scoreboard table_model;
    bit [63:0]      id_pool[20];
    bit             stall_quiet;
    int             idle_cycles = 0;

    overlay_layer_rank_policy_unit dut (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
            out_stall <= stall_quiet ? 1'b0 : ($urandom_range(99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_model.check_word(enable, rank, status);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Holds valid high into the next word when no gap follows.
    task automatic send(bit [1:0] o, bit [63:0] id);
        int gap;
        in_valid <= 1;
        op <= o;
        surface_id <= id;
        do @(posedge clk); while (in_stall);
        table_model.note_word(o, id);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            op <= 2'($urandom());
            surface_id <= {$urandom(), $urandom()};
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (table_model.answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        table_model.write_reg(idx, val);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_phase(int items);
        int r;
        bit [63:0] id;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            id = ($urandom_range(19) == 0) ? {$urandom(), $urandom()}
                                           : id_pool[$urandom_range(19)];
            if (r < 35) send(olrp_pkg::OP_TICK, {$urandom(), $urandom()});
            else if (r < 70) send(olrp_pkg::OP_UPDATE, id);
            else if (r < 78) send(olrp_pkg::OP_DELETE, id);
            else send(olrp_pkg::OP_QUERY, id);
        end
    endtask

    initial
    begin
        table_model = new();
        table_model.clear();
        stall_quiet = 0;
        rst_n = 0;
        in_valid = 0;
        op = olrp_pkg::OP_TICK;
        surface_id = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        id_pool[0] = 64'd0;
        id_pool[1] = '1;
        for (int i = 2; i < 20; i++)
            id_pool[i] = {$urandom(), $urandom()};
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: unknown surfaces, extreme ids, a full table, a stale query.
        send(olrp_pkg::OP_QUERY, 64'd0);
        send(olrp_pkg::OP_DELETE, '1);
        send(olrp_pkg::OP_UPDATE, 64'd0);
        send(olrp_pkg::OP_UPDATE, '1);
        send(olrp_pkg::OP_TICK, '1);
        send(olrp_pkg::OP_UPDATE, 64'd0);
        send(olrp_pkg::OP_QUERY, 64'd0);
        send(olrp_pkg::OP_QUERY, '1);
        for (int i = 2; i < 16; i++)
            send(olrp_pkg::OP_UPDATE, id_pool[i]);
        send(olrp_pkg::OP_UPDATE, id_pool[16]);
        send(olrp_pkg::OP_DELETE, id_pool[5]);
        send(olrp_pkg::OP_QUERY, id_pool[3]);
        drain();
        write_reg(olrp_pkg::CFG_STALE_LIMIT, 32'd0);
        write_reg(olrp_pkg::CFG_MAX_ENABLED, 32'd0);
        write_reg(2'd2, 32'hffff_ffff);
        send(olrp_pkg::OP_QUERY, '1);
        send(olrp_pkg::OP_TICK, 64'd0);
        send(olrp_pkg::OP_QUERY, '1);
        drain();

        write_reg(olrp_pkg::CFG_STALE_LIMIT, 32'hffff_ffff);
        write_reg(olrp_pkg::CFG_MAX_ENABLED, 32'd16);
        random_phase(400);
        drain();
        stall_quiet = 1;
        write_reg(olrp_pkg::CFG_STALE_LIMIT, 32'd100);
        write_reg(olrp_pkg::CFG_MAX_ENABLED, 32'd8);
        random_phase(400);
        drain();
        stall_quiet = 0;
        write_reg(olrp_pkg::CFG_STALE_LIMIT, 32'd6);
        write_reg(olrp_pkg::CFG_MAX_ENABLED, 32'd1);
        random_phase(400);
        drain();
        write_reg(olrp_pkg::CFG_STALE_LIMIT, 32'd0);
        write_reg(olrp_pkg::CFG_MAX_ENABLED, 32'd31);
        write_reg(2'd3, 32'd5);
        random_phase(300);
        drain();
        write_reg(olrp_pkg::CFG_STALE_LIMIT, $urandom_range(40));
        write_reg(olrp_pkg::CFG_MAX_ENABLED, $urandom_range(16));
        random_phase(420);
        drain();
        repeat (300) @(posedge clk);

        if (table_model.errors == 0 && table_model.answers.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/olrp_pkg.sv
rtl/olrp_ring_mem.sv
rtl/olrp_mul.sv
rtl/overlay_layer_rank_policy_unit.sv
tb/tb.sv
